@@ hw/rtl/gbfc_pkg.sv @@
`default_nettype none

package gbfc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LENGTH_W  = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0]   SYNC_FIRST   = 8'hB5;
  localparam logic [BYTE_W-1:0]   SYNC_SECOND  = 8'h62;
  localparam logic [LENGTH_W-1:0] FLOOR_LENGTH = 16'd8;

  localparam logic [LENGTH_W-1:0] MIN_LENGTH_RESET = 16'd8;
  localparam logic [LENGTH_W-1:0] MAX_LENGTH_RESET = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LENGTH = 2'd0,
    REG_MAX_LENGTH = 2'd1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID    = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_LENGTH   = 2'd2
  } status_t;

  // One byte handed from the input register to the parser
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } step_t;

  typedef struct packed {
    status_t             status;
    logic [LENGTH_W-1:0] length;
    logic [BYTE_W-1:0]   msg_class;
    logic [BYTE_W-1:0]   msg_id;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/gbfc_in_reg.sv @@
`default_nettype none

module gbfc_in_reg (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [gbfc_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                  out_ready,
  output gbfc_pkg::step_t            step
);
  import gbfc_pkg::*;

  logic              full;
  logic [BYTE_W-1:0] data;
  logic              advance;
  logic              accept;

  assign advance  = full && out_ready;
  assign in_stall = full && !out_ready;
  assign accept   = in_valid && !in_stall;

  assign step.valid = advance;
  assign step.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data <= data_byte;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gbfc_parser.sv @@
`default_nettype none

module gbfc_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [gbfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gbfc_pkg::LENGTH_W-1:0]  cfg_data,
  input  gbfc_pkg::step_t                     step,
  output logic                                result_valid,
  output gbfc_pkg::result_t                   result
);
  import gbfc_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_CLASS = 3'd2,
    PH_ID    = 3'd3,
    PH_LENHI = 3'd4,
    PH_LENLO = 3'd5,
    PH_BODY  = 3'd6
  } phase_t;

  logic [LENGTH_W-1:0] min_length;
  logic [LENGTH_W-1:0] max_length;

  phase_t              phase, phase_next;
  logic [LENGTH_W-1:0] byte_index, byte_index_next;
  logic [LENGTH_W-1:0] length_value, length_value_next;
  logic [BYTE_W-1:0]   class_value, class_value_next;
  logic [BYTE_W-1:0]   id_value, id_value_next;
  logic [BYTE_W-1:0]   sum_first, sum_second;
  logic [BYTE_W-1:0]   sum_first_next, sum_second_next;
  logic                check_mismatch, check_mismatch_next;

  logic [BYTE_W-1:0]   b;
  logic [BYTE_W-1:0]   add_first, add_second;
  logic [LENGTH_W:0]   index_plus2;
  logic [LENGTH_W-1:0] low_limit;
  logic [LENGTH_W-1:0] length_lo;
  logic                length_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_LENGTH: min_length <= cfg_data;
        REG_MAX_LENGTH: max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign b           = step.data;
  assign add_first   = sum_first + b;
  assign add_second  = sum_second + add_first;
  assign index_plus2 = {1'b0, byte_index} + (LENGTH_W+1)'(2);
  assign length_lo   = {length_value[LENGTH_W-1:BYTE_W], b};
  assign low_limit   = (min_length < FLOOR_LENGTH) ? FLOOR_LENGTH : min_length;
  assign length_bad  = (length_lo < low_limit) || (length_lo > max_length);

  always_comb begin
    phase_next          = phase;
    byte_index_next     = byte_index;
    length_value_next   = length_value;
    class_value_next    = class_value;
    id_value_next       = id_value;
    sum_first_next      = sum_first;
    sum_second_next     = sum_second;
    check_mismatch_next = check_mismatch;
    result_valid        = 1'b0;
    result.status       = ST_VALID;
    result.length       = length_value;
    result.msg_class    = class_value;
    result.msg_id       = id_value;

    case (phase)
      PH_SYNC2: begin
        if (b == SYNC_SECOND) begin
          phase_next          = PH_CLASS;
          byte_index_next     = LENGTH_W'(2);
          sum_first_next      = '0;
          sum_second_next     = '0;
          check_mismatch_next = 1'b0;
        end else if (b != SYNC_FIRST) begin
          phase_next      = PH_HUNT;
          byte_index_next = '0;
        end
      end
      PH_CLASS: begin
        class_value_next = b;
        sum_first_next   = add_first;
        sum_second_next  = add_second;
        phase_next       = PH_ID;
        byte_index_next  = LENGTH_W'(3);
      end
      PH_ID: begin
        id_value_next   = b;
        sum_first_next  = add_first;
        sum_second_next = add_second;
        phase_next      = PH_LENHI;
        byte_index_next = LENGTH_W'(4);
      end
      PH_LENHI: begin
        length_value_next = {b, {BYTE_W{1'b0}}};
        sum_first_next    = add_first;
        sum_second_next   = add_second;
        phase_next        = PH_LENLO;
        byte_index_next   = LENGTH_W'(5);
      end
      PH_LENLO: begin
        length_value_next = length_lo;
        sum_first_next    = add_first;
        sum_second_next   = add_second;
        result.length     = length_lo;
        if (length_bad) begin
          result_valid    = 1'b1;
          result.status   = ST_LENGTH;
          phase_next      = PH_HUNT;
          byte_index_next = '0;
        end else begin
          phase_next      = PH_BODY;
          byte_index_next = LENGTH_W'(6);
        end
      end
      PH_BODY: begin
        if (index_plus2 < {1'b0, length_value}) begin
          sum_first_next  = add_first;
          sum_second_next = add_second;
          byte_index_next = byte_index + LENGTH_W'(1);
        end else if (index_plus2 == {1'b0, length_value}) begin
          check_mismatch_next = (b != sum_first);
          byte_index_next     = byte_index + LENGTH_W'(1);
        end else begin
          // last byte: second check byte closes the frame
          result_valid    = 1'b1;
          result.status   = (check_mismatch || (b != sum_second)) ? ST_CHECKSUM : ST_VALID;
          phase_next      = PH_HUNT;
          byte_index_next = '0;
        end
      end
      default: begin
        phase_next      = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
        byte_index_next = (b == SYNC_FIRST) ? LENGTH_W'(1) : '0;
      end
    endcase

    if (!step.valid) begin
      result_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      byte_index     <= '0;
      length_value   <= '0;
      class_value    <= '0;
      id_value       <= '0;
      sum_first      <= '0;
      sum_second     <= '0;
      check_mismatch <= 1'b0;
    end else if (step.valid) begin
      phase          <= phase_next;
      byte_index     <= byte_index_next;
      length_value   <= length_value_next;
      class_value    <= class_value_next;
      id_value       <= id_value_next;
      sum_first      <= sum_first_next;
      sum_second     <= sum_second_next;
      check_mismatch <= check_mismatch_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gbfc_out_reg.sv @@
`default_nettype none

module gbfc_out_reg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          result_valid,
  input  gbfc_pkg::result_t                  result,
  output logic                               out_ready,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [gbfc_pkg::STATUS_W-1:0]      frame_status,
  output logic [gbfc_pkg::LENGTH_W-1:0]      frame_length,
  output logic [gbfc_pkg::BYTE_W-1:0]        message_class,
  output logic [gbfc_pkg::BYTE_W-1:0]        message_id
);
  import gbfc_pkg::*;

  result_t held;

  // free slot, or the held transaction leaves this cycle
  assign out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid) begin
      held <= result;
    end
  end

  assign frame_status  = held.status;
  assign frame_length  = held.length;
  assign message_class = held.msg_class;
  assign message_id    = held.msg_id;

endmodule

`default_nettype wire

@@ hw/rtl/gnss_binary_frame_checker_unit.sv @@
// Channel  Direction  Signals                                         Transfer
// in       input      in_valid, in_stall, data_byte                   valid & !stall
// out      output     out_valid, out_stall, frame_status,
//                     frame_length, message_class, message_id         valid & !stall
// cfg      input      cfg_write, cfg_index, cfg_data                  cfg_write
//
// One byte per cycle sustained while the result side does not stall. Each byte is
// registered in the input register, the parser updates its state from it, and any
// result lands in the output register, which drives the result port.
// Synchronous active-high reset clears state, restores min_length 8 and max_length
// 65535. A stall on the result side backs up through the input register to in_stall.
`default_nettype none

module gnss_binary_frame_checker_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [gbfc_pkg::BYTE_W-1:0]    data_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [gbfc_pkg::STATUS_W-1:0]       frame_status,
  output logic [gbfc_pkg::LENGTH_W-1:0]       frame_length,
  output logic [gbfc_pkg::BYTE_W-1:0]         message_class,
  output logic [gbfc_pkg::BYTE_W-1:0]         message_id,
  input  wire logic                           cfg_write,
  input  wire logic [gbfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gbfc_pkg::LENGTH_W-1:0]  cfg_data
);
  import gbfc_pkg::*;

  step_t   step;
  logic    out_ready;
  logic    result_valid;
  result_t result;

  gbfc_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .out_ready (out_ready),
    .step      (step)
  );

  gbfc_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step         (step),
    .result_valid (result_valid),
    .result       (result)
  );

  gbfc_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .result_valid  (result_valid),
    .result        (result),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_status  (frame_status),
    .frame_length  (frame_length),
    .message_class (message_class),
    .message_id    (message_id)
  );

endmodule

`default_nettype wire

@@ hw/rtl/gbfc_checker.sv @@
`default_nettype none

module gbfc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [gbfc_pkg::STATUS_W-1:0]  frame_status,
  input wire logic [gbfc_pkg::LENGTH_W-1:0]  frame_length,
  input wire logic [gbfc_pkg::BYTE_W-1:0]    message_class,
  input wire logic [gbfc_pkg::BYTE_W-1:0]    message_id
);
  import gbfc_pkg::*;

  // hold a stalled result transaction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_status) && $stable(frame_length)
      && $stable(message_class) && $stable(message_id))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_status == ST_VALID || frame_status == ST_CHECKSUM
      || frame_status == ST_LENGTH)
    else $error("undefined frame status");

  // a frame that passed the length check is at least header plus checksum long
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status != ST_LENGTH |-> frame_length >= FLOOR_LENGTH)
    else $error("checked frame shorter than minimum");

  // with the result slot free, input must flow
  assert property (@(posedge clk) !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind gnss_binary_frame_checker_unit gbfc_checker u_gbfc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .frame_status  (frame_status),
  .frame_length  (frame_length),
  .message_class (message_class),
  .message_id    (message_id)
);

`default_nettype wire
